// File: rtl/fpl_pkg.sv
// ============================================================================
// fpl_pkg: shared constants and types for the fixed-point logarithm.
// Holds the field widths, the base-10 constants and the item format that
// travels down the squaring pipeline.
// ============================================================================
package fpl_pkg;

    localparam int FRAC_BITS = 20;
    localparam int SAMPLE_W  = 31;
    localparam int CNT_W     = $clog2(SAMPLE_W);
    localparam int INT_W     = CNT_W + 1;
    localparam int MANT_W    = FRAC_BITS + 1;
    localparam int RES_W     = INT_W + FRAC_BITS;
    localparam int MAG_W     = RES_W - 1;
    localparam int SQ_STAGES = FRAC_BITS;

    localparam int LOG2_TEN_W = 22;
    localparam int QUO_W      = 23;
    localparam int REM_W      = LOG2_TEN_W + 2;
    localparam int RECIP_W    = 25;
    localparam int RECIP_SHIFT = MAG_W + FRAC_BITS + 1;

    localparam logic [LOG2_TEN_W-1:0] LOG2_TEN_Q20 = LOG2_TEN_W'(3483294);
    localparam logic [RES_W-1:0] LOG10_ZERO_Q20 = RES_W'(-32'sd6628709);
    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(LOG2_TEN_Q20);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    localparam logic signed [INT_W-1:0] INT_TOP = INT_W'(SAMPLE_W - 1 - FRAC_BITS);

    localparam logic CMD_LOG2  = 1'b0;
    localparam logic CMD_LOG10 = 1'b1;

    typedef struct packed {
        logic signed [INT_W-1:0] int_part;
        logic [FRAC_BITS-1:0]    frac;
        logic [MANT_W-1:0]       mant;
        logic                    cmd;
        logic                    zero;
    } sq_item_t;

endpackage

// File: rtl/fpl_norm.sv
// ============================================================================
// fpl_norm: leading-one search and mantissa normalization.
// Two register stages find the leading one in binary steps and left-justify
// the sample, giving the integer part of log2 and a mantissa in [1,2).
// ============================================================================
module fpl_norm
    import fpl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [SAMPLE_W-1:0] sample_value,
    output logic                out_valid,
    input  logic                out_ready,
    output sq_item_t            out_item
);

    logic                valid_a_reg;
    logic                valid_b_reg;
    logic                en_a;
    logic                en_b;
    logic [SAMPLE_W-1:0] xs_a_reg;
    logic [SAMPLE_W-1:0] xs_a_next;
    logic [CNT_W-1:0]    cnt_a_reg;
    logic [CNT_W-1:0]    cnt_a_next;
    logic                cmd_a_reg;
    logic                zero_a_reg;
    logic [SAMPLE_W-1:0] sh16;
    logic [SAMPLE_W-1:0] sh8;
    logic                c16;
    logic                c8;
    logic                c4;
    logic [SAMPLE_W-1:0] sh2;
    logic [SAMPLE_W-1:0] norm_x;
    logic                c2;
    logic                c1;
    logic [CNT_W-1:0]    lz;
    sq_item_t            item_b_reg;
    sq_item_t            item_b_next;

    assign en_b     = !valid_b_reg || out_ready;
    assign en_a     = !valid_a_reg || en_b;
    assign in_ready = en_a;

    always_comb
    begin
        c16        = (sample_value[SAMPLE_W-1 -: 16] == '0);
        sh16       = c16 ? (sample_value << 16) : sample_value;
        c8         = (sh16[SAMPLE_W-1 -: 8] == '0);
        sh8        = c8 ? (sh16 << 8) : sh16;
        c4         = (sh8[SAMPLE_W-1 -: 4] == '0);
        xs_a_next  = c4 ? (sh8 << 4) : sh8;
        cnt_a_next = {c16, c8, c4, 2'b00};
    end

    always_comb
    begin
        c2     = (xs_a_reg[SAMPLE_W-1 -: 2] == '0);
        sh2    = c2 ? (xs_a_reg << 2) : xs_a_reg;
        c1     = !sh2[SAMPLE_W-1];
        norm_x = c1 ? (sh2 << 1) : sh2;
        lz     = cnt_a_reg | {3'b000, c2, c1};
        item_b_next.int_part = INT_TOP - $signed({1'b0, lz});
        item_b_next.frac     = '0;
        item_b_next.mant     = norm_x[SAMPLE_W-1 -: MANT_W];
        item_b_next.cmd      = cmd_a_reg;
        item_b_next.zero     = zero_a_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (en_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            xs_a_reg   <= xs_a_next;
            cnt_a_reg  <= cnt_a_next;
            cmd_a_reg  <= command;
            zero_a_reg <= (sample_value == '0);
        end
        if (en_b && valid_a_reg)
        begin
            item_b_reg <= item_b_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_item  = item_b_reg;

endmodule

// File: rtl/fpl_sq_stage.sv
// ============================================================================
// fpl_sq_stage: one squaring step of the log2 fraction.
// Squares the mantissa, emits one fraction bit and halves the mantissa when
// the square has reached two.
// ============================================================================
module fpl_sq_stage
    import fpl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sq_item_t in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output sq_item_t out_item
);

    logic                  valid_reg;
    logic                  en;
    logic [2*MANT_W-1:0]   prod;
    logic [MANT_W:0]       sq;
    logic                  bit_out;
    sq_item_t              item_reg;
    sq_item_t              item_next;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        prod    = in_item.mant * in_item.mant;
        sq      = prod[FRAC_BITS +: MANT_W+1];
        bit_out = sq[MANT_W];
        item_next          = in_item;
        item_next.mant     = bit_out ? sq[MANT_W:1] : sq[MANT_W-1:0];
        item_next.frac     = {in_item.frac[FRAC_BITS-2:0], bit_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: rtl/fpl_log10.sv
// ============================================================================
// fpl_log10: base conversion and result selection.
// Divides the log2 result by log2(10) through a reciprocal multiply with one
// remainder correction, then picks the base and the zero-operand values.
// ============================================================================
module fpl_log10
    import fpl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  sq_item_t                in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [RES_W-1:0] log_result,
    output logic                    zero_error
);

    localparam int NSTG = 5;
    localparam logic [REM_W-1:0] LOG2_TEN_REM = REM_W'(LOG2_TEN_Q20);

    logic [NSTG-1:0] valid_reg;
    logic [NSTG:0]   en;

    logic [RES_W-1:0] y1_reg, y2_reg, y3_reg, y4_reg;
    logic [MAG_W-1:0] mag1_reg, mag2_reg, mag3_reg;
    logic             neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic             cmd1_reg, cmd2_reg, cmd3_reg, cmd4_reg;
    logic             zero1_reg, zero2_reg, zero3_reg, zero4_reg;
    logic [QUO_W-1:0] qe2_reg, qe3_reg;
    logic [REM_W-1:0] qc3_reg;
    logic [QUO_W-1:0] q4_reg;
    logic signed [RES_W-1:0] log_result_reg;
    logic             zero_error_reg;

    logic [RES_W-1:0]            y1_next;
    logic [MAG_W-1:0]            mag1_next;
    logic [MAG_W+RECIP_W-1:0]    recip_prod;
    logic [QUO_W+LOG2_TEN_W-1:0] qc_prod;
    logic [MAG_W+FRAC_BITS-1:0]  num;
    logic [REM_W-1:0]            rem;
    logic [QUO_W-1:0]            q4_next;
    logic [RES_W-1:0]            q_ext;
    logic [RES_W-1:0]            log_result_next;

    always_comb
    begin
        en[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end
    assign in_ready = en[0];

    always_comb
    begin
        y1_next   = {in_item.int_part, in_item.frac};
        mag1_next = y1_next[RES_W-1] ? MAG_W'(-y1_next) : y1_next[MAG_W-1:0];
    end

    assign recip_prod = mag1_reg * RECIP;
    assign qc_prod    = qe2_reg * LOG2_TEN_Q20;

    always_comb
    begin
        num     = {mag3_reg, {FRAC_BITS{1'b0}}};
        rem     = num[REM_W-1:0] - qc3_reg;
        q4_next = (rem >= LOG2_TEN_REM) ? qe3_reg + QUO_W'(1) : qe3_reg;
    end

    always_comb
    begin
        q_ext = {{(RES_W-QUO_W){1'b0}}, q4_reg};
        if (zero4_reg)
        begin
            log_result_next = (cmd4_reg == CMD_LOG10) ? LOG10_ZERO_Q20 : '0;
        end
        else if (cmd4_reg == CMD_LOG10)
        begin
            log_result_next = neg4_reg ? -q_ext : q_ext;
        end
        else
        begin
            log_result_next = y4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            y1_reg    <= y1_next;
            mag1_reg  <= mag1_next;
            neg1_reg  <= y1_next[RES_W-1];
            cmd1_reg  <= in_item.cmd;
            zero1_reg <= in_item.zero;
        end
        if (en[1] && valid_reg[0])
        begin
            y2_reg    <= y1_reg;
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            cmd2_reg  <= cmd1_reg;
            zero2_reg <= zero1_reg;
            qe2_reg   <= recip_prod[RECIP_SHIFT-FRAC_BITS +: QUO_W];
        end
        if (en[2] && valid_reg[1])
        begin
            y3_reg    <= y2_reg;
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            cmd3_reg  <= cmd2_reg;
            zero3_reg <= zero2_reg;
            qe3_reg   <= qe2_reg;
            qc3_reg   <= qc_prod[REM_W-1:0];
        end
        if (en[3] && valid_reg[2])
        begin
            y4_reg    <= y3_reg;
            neg4_reg  <= neg3_reg;
            cmd4_reg  <= cmd3_reg;
            zero4_reg <= zero3_reg;
            q4_reg    <= q4_next;
        end
        if (en[4] && valid_reg[3])
        begin
            log_result_reg <= log_result_next;
            zero_error_reg <= zero4_reg && (cmd4_reg == CMD_LOG2);
        end
    end

    assign out_valid  = valid_reg[NSTG-1];
    assign log_result = log_result_reg;
    assign zero_error = zero_error_reg;

endmodule

// File: rtl/fixed_point_log2_log10.sv
// ============================================================================
// fixed_point_log2_log10: pipelined base-2 / base-10 logarithm, Q11.20 to Q20.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   command, sample_value
//   output    out_valid / out_ready log_result, zero_error
//
// One transaction is accepted per cycle while the output is not stalled; the
// pipeline has two normalization stages, twenty squaring stages (one multiplier
// each) and five base-conversion stages.
// Reset clears only the stage valid bits; the data registers are not reset.
// Each stage holds its contents while the next one is full, so a stalled
// output fills empty stages first and nothing is dropped or repeated.
// ============================================================================
module fixed_point_log2_log10
    import fpl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    command,
    input  logic [SAMPLE_W-1:0]     sample_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [RES_W-1:0] log_result,
    output logic                    zero_error
);

    sq_item_t             sq_item [SQ_STAGES+1];
    logic [SQ_STAGES:0]   sq_valid;
    logic [SQ_STAGES:0]   sq_ready;

    fpl_norm u_norm (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .sample_value (sample_value),
        .out_valid    (sq_valid[0]),
        .out_ready    (sq_ready[0]),
        .out_item     (sq_item[0])
    );

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_sq
        fpl_sq_stage u_sq (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[k]),
            .in_ready  (sq_ready[k]),
            .in_item   (sq_item[k]),
            .out_valid (sq_valid[k+1]),
            .out_ready (sq_ready[k+1]),
            .out_item  (sq_item[k+1])
        );
    end

    fpl_log10 u_log10 (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sq_valid[SQ_STAGES]),
        .in_ready   (sq_ready[SQ_STAGES]),
        .in_item    (sq_item[SQ_STAGES]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .log_result (log_result),
        .zero_error (zero_error)
    );

`ifndef SYNTHESIS
    a_err_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_error |-> log_result == '0)
        else $error("zero_error set with nonzero log_result");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> log_result >= -20971520 && log_result <= 11534336)
        else $error("log_result outside the Q20 range of the logarithm");

    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while the output side accepts");
`endif

endmodule

// File: bench/tb.sv
// ============================================================================
// tb: self-checking bench for the fixed-point log2 / log10 pipeline.
// A driver process offers samples from a queue and predicts the Q20
// logarithm of each accepted transaction. A monitor process compares every
// accepted output transaction with the oldest prediction. Both handshakes
// idle at random, and the output is held off once for a long stretch so
// that the pipeline fills and stalls its input.
// ============================================================================
module tb;
    import fpl_pkg::*;

    localparam int N_RANDOM       = 1030;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 300;
    localparam int REPORT_MAX     = 10;
    localparam longint unsigned LOG2_TEN = 64'd3483294;
    localparam longint LOG10_OF_ZERO     = -64'sd6628709;

    typedef struct {
        logic                cmd;
        logic [SAMPLE_W-1:0] sample;
    } sample_item_t;

    typedef struct {
        logic signed [RES_W-1:0] value;
        logic                    err;
    } log_out_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    command = 1'b0;
    logic [SAMPLE_W-1:0]     sample_value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [RES_W-1:0] log_result;
    logic                    zero_error;

    sample_item_t pending_samples[$];
    log_out_t     expected_logs[$];

    int   n_items;
    int   n_sent;
    int   n_checked;
    int   n_mismatch;
    int   n_log10;
    int   n_zero;
    int   cycles;
    int   in_stall_cycles;
    int   send_gap;
    int   recv_stall;
    int   hold_left;
    logic holding = 1'b0;
    logic hold_done = 1'b0;

    fixed_point_log2_log10 uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .log_result   (log_result),
        .zero_error   (zero_error)
    );

    function automatic longint log2_q20(input logic [SAMPLE_W-1:0] x);
        int          lead;
        logic [63:0] mant;
        longint      frac;
        lead = 0;
        frac = 0;
        for (int b = 0; b < SAMPLE_W; b++)
        begin
            if (x[b])
                lead = b;
        end
        if (lead >= FRAC_BITS)
            mant = 64'(x) >> (lead - FRAC_BITS);
        else
            mant = 64'(x) << (FRAC_BITS - lead);
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            mant = (mant * mant) >> FRAC_BITS;
            frac = frac << 1;
            if (mant >= (64'd2 << FRAC_BITS))
            begin
                mant = mant >> 1;
                frac = frac | 64'd1;
            end
        end
        return longint'(lead - FRAC_BITS) * (longint'(1) << FRAC_BITS) + frac;
    endfunction

    // Division by log2(10) in Q20, truncating toward zero.
    function automatic longint log10_from_log2(input longint y);
        longint unsigned mag;
        longint unsigned whole;
        longint unsigned rest;
        longint unsigned quo;
        if (y < 0)
            mag = -y;
        else
            mag = y;
        whole = mag / LOG2_TEN;
        rest  = mag % LOG2_TEN;
        quo   = (whole << FRAC_BITS) + (rest << FRAC_BITS) / LOG2_TEN;
        return (y < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic log_out_t predict_log(input logic cmd, input logic [SAMPLE_W-1:0] x);
        log_out_t r;
        longint   v;
        r.err = 1'b0;
        if (x == '0)
        begin
            if (cmd == CMD_LOG10)
            begin
                v = LOG10_OF_ZERO;
            end
            else
            begin
                v = 0;
                r.err = 1'b1;
            end
        end
        else
        begin
            v = log2_q20(x);
            if (cmd == CMD_LOG10)
                v = log10_from_log2(v);
        end
        r.value = RES_W'(v);
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic add_sample(input logic cmd, input logic [SAMPLE_W-1:0] x);
        sample_item_t item;
        item.cmd = cmd;
        item.sample = x;
        pending_samples.push_back(item);
        n_items++;
        if (cmd == CMD_LOG10)
            n_log10++;
        if (x == '0)
            n_zero++;
    endtask

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, expected_logs.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Driver: offers queued samples, predicts each accepted transaction.
    always @(posedge clk)
    begin
        logic         next_valid;
        sample_item_t item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                expected_logs.push_back(predict_log(command, sample_value));
                n_sent <= n_sent + 1;
                next_valid = 1'b0;
                if (!holding && (n_sent / 128) % 3 != 0)
                    send_gap = idle_len();
            end
            else if (in_valid)
            begin
                in_stall_cycles <= in_stall_cycles + 1;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_samples.size() > 0)
                begin
                    item = pending_samples.pop_front();
                    command <= item.cmd;
                    sample_value <= item.sample;
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // Long output hold-off, once, after the first few hundred transactions.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            holding <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
        end
        else if (holding)
        begin
            if (hold_left == 1)
            begin
                holding <= 1'b0;
                hold_done <= 1'b1;
            end
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && n_sent >= HOLD_AFTER)
        begin
            holding <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Monitor: checks each output transaction against the oldest prediction.
    always @(posedge clk)
    begin
        log_out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_checked++;
                if (expected_logs.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= REPORT_MAX)
                        $display("unexpected result: log_result %0d zero_error %0b",
                                 log_result, zero_error);
                end
                else
                begin
                    want = expected_logs.pop_front();
                    if (log_result !== want.value || zero_error !== want.err)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= REPORT_MAX)
                            $display("result %0d: log_result exp %0d got %0d, %s%0b got %0b",
                                     n_checked, want.value, log_result,
                                     "zero_error exp ", want.err, zero_error);
                    end
                end
            end
            if (recv_stall > 0)
                recv_stall--;
            else if ((n_checked / 150) % 3 != 1 && $urandom_range(0, 3) == 0)
                recv_stall = idle_len();
            out_ready <= !holding && recv_stall == 0;
        end
    end

    initial
    begin
        logic [SAMPLE_W-1:0] x;
        logic                c;
        add_sample(CMD_LOG2, '0);
        add_sample(CMD_LOG10, '0);
        add_sample(CMD_LOG2, SAMPLE_W'(1));
        add_sample(CMD_LOG10, SAMPLE_W'(1));
        add_sample(CMD_LOG2, '1);
        add_sample(CMD_LOG10, '1);
        add_sample(CMD_LOG2, SAMPLE_W'(1) << FRAC_BITS);
        add_sample(CMD_LOG10, SAMPLE_W'(1) << FRAC_BITS);
        add_sample(CMD_LOG10, SAMPLE_W'(10) << FRAC_BITS);
        add_sample(CMD_LOG2, (SAMPLE_W'(1) << FRAC_BITS) - 1);
        add_sample(CMD_LOG2, (SAMPLE_W'(1) << FRAC_BITS) + 1);
        add_sample(CMD_LOG10, SAMPLE_W'(1) << (FRAC_BITS - 1));
        add_sample(CMD_LOG10, SAMPLE_W'(3));
        add_sample(CMD_LOG2, SAMPLE_W'(32'h5555_5555));
        add_sample(CMD_LOG10, SAMPLE_W'(32'h5555_5555));
        add_sample(CMD_LOG2, SAMPLE_W'(32'h2AAA_AAAA));
        add_sample(CMD_LOG10, SAMPLE_W'(32'h2AAA_AAAA));
        add_sample(CMD_LOG2, SAMPLE_W'(1) << (SAMPLE_W - 1));
        add_sample(CMD_LOG2, SAMPLE_W'(1482910));
        add_sample(CMD_LOG2, SAMPLE_W'(1482911));
        add_sample(CMD_LOG10, SAMPLE_W'(100) << FRAC_BITS);
        add_sample(CMD_LOG2, SAMPLE_W'(3) << FRAC_BITS);
        for (int k = 0; k < N_RANDOM; k++)
        begin
            c = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: x = '0;
                1, 2: x = SAMPLE_W'($urandom) >> $urandom_range(0, SAMPLE_W - 1);
                3: x = (SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1))
                       + SAMPLE_W'($urandom_range(0, 2)) - SAMPLE_W'(1);
                4: x = (SAMPLE_W'(1) << FRAC_BITS) - SAMPLE_W'(2048)
                       + SAMPLE_W'($urandom_range(0, 4096));
                default: x = SAMPLE_W'($urandom);
            endcase
            add_sample(c, x);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (!(n_sent == n_items && expected_logs.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d samples sent (%0d in base 10, %0d zero operands), %0d results checked",
                 n_sent, n_log10, n_zero, n_checked);
        $display("output held off for %0d cycles; input stalled for %0d cycles in total",
                 HOLD_CYCLES, in_stall_cycles);
        if (n_mismatch == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("%0d mismatches", n_mismatch);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/fpl_pkg.sv
rtl/fpl_norm.sv
rtl/fpl_sq_stage.sv
rtl/fpl_log10.sv
rtl/fixed_point_log2_log10.sv
bench/tb.sv
